FILE: src/nvb_pkg.sv
// Package for the NV12 to BGR converter: transaction payload types,
// sum width and the clamp helper. No dependencies.
package nvb_pkg;

  localparam int SumW = 19;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       chroma_fresh;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] blue_first;
    logic [7:0] green_first;
    logic [7:0] red_first;
    logic [7:0] blue_second;
    logic [7:0] green_second;
    logic [7:0] red_second;
    logic       row_end;
  } pix_out_t;

  typedef struct packed {
    logic mul_en;
    logic sum_en;
  } stage_en_t;

  // Negative sums clamp to 0, anything at or above 256 after the shift to 255.
  function automatic logic [7:0] sat_to_byte(input logic signed [SumW-1:0] s);
    logic [7:0] r;
    if (s[SumW-1]) begin
      r = 8'd0;
    end else if (s[SumW-2:16] != '0) begin
      r = 8'hFF;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

endpackage

FILE: src/nvb_if.sv
// Handshake interfaces for pixel input, pixel output and configuration.
// Depends on nvb_pkg for the payload types.
interface nvb_in_if import nvb_pkg::*; ();
  logic    valid;
  logic    ready;
  pix_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nvb_out_if import nvb_pkg::*; ();
  logic     valid;
  logic     ready;
  pix_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface nvb_cfg_if;
  logic        valid;
  logic        ready;
  logic [10:0] pairs_per_row;
  modport source (output valid, output pairs_per_row, input ready);
  modport sink (input valid, input pairs_per_row, output ready);
endinterface

FILE: src/nvb_line_buf.sv
// Chroma line buffer: single-port synchronous RAM with a registered read.
// No dependencies.
module nvb_line_buf #(
  parameter int Depth = 1024,
  parameter int AddrW = 10,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [DataW-1:0] wdata_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/nvb_pixel_math.sv
// Color math for one pixel pair: products stage, then sum/round/clamp stage.
// Depends on nvb_pkg for sum width, stage enables and sat_to_byte.
module nvb_pixel_math import nvb_pkg::*; (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  logic [7:0] luma0_i,
  input  logic [7:0] luma1_i,
  input  logic [7:0] cb_i,
  input  logic [7:0] cr_i,
  output logic [7:0] blue0_o,
  output logic [7:0] green0_o,
  output logic [7:0] red0_o,
  output logic [7:0] blue1_o,
  output logic [7:0] green1_o,
  output logic [7:0] red1_o
);

  logic [8:0]             c0_diff, c1_diff;
  logic [7:0]             c0, c1;
  logic signed [7:0]      d8, e8;
  logic signed [SumW-1:0] c0x, c1x, dx, ex;
  logic signed [SumW-1:0] yc0_q, yc1_q, bd_q, gd_q, ge_q, re_q;
  logic signed [SumW-1:0] yc0_d, yc1_d, bd_d, gd_d, ge_d, re_d;
  logic signed [SumW-1:0] b0, g0, r0, b1, g1, r1;
  logic signed [SumW-1:0] rnd;
  logic [7:0] blue0_q, green0_q, red0_q, blue1_q, green1_q, red1_q;

  assign c0_diff = {1'b0, luma0_i} - 9'd16;
  assign c1_diff = {1'b0, luma1_i} - 9'd16;
  assign c0 = c0_diff[8] ? 8'd0 : c0_diff[7:0];
  assign c1 = c1_diff[8] ? 8'd0 : c1_diff[7:0];
  // x - 128 of an unsigned byte is the byte with its top bit flipped, as signed
  assign d8 = signed'({~cb_i[7], cb_i[6:0]});
  assign e8 = signed'({~cr_i[7], cr_i[6:0]});
  assign c0x = signed'({{(SumW-8){1'b0}}, c0});
  assign c1x = signed'({{(SumW-8){1'b0}}, c1});
  assign dx = SumW'(d8);
  assign ex = SumW'(e8);

  assign yc0_d = c0x * SumW'(298);
  assign yc1_d = c1x * SumW'(298);
  assign bd_d  = dx * SumW'(516);
  assign gd_d  = dx * SumW'(100);
  assign ge_d  = ex * SumW'(208);
  assign re_d  = ex * SumW'(409);

  always_ff @(posedge clk_i) begin
    if (en_i.mul_en) begin
      yc0_q <= yc0_d;
      yc1_q <= yc1_d;
      bd_q  <= bd_d;
      gd_q  <= gd_d;
      ge_q  <= ge_d;
      re_q  <= re_d;
    end
  end

  assign rnd = SumW'(128);
  assign b0 = yc0_q + bd_q + rnd;
  assign g0 = yc0_q - gd_q - ge_q + rnd;
  assign r0 = yc0_q + re_q + rnd;
  assign b1 = yc1_q + bd_q + rnd;
  assign g1 = yc1_q - gd_q - ge_q + rnd;
  assign r1 = yc1_q + re_q + rnd;

  always_ff @(posedge clk_i) begin
    if (en_i.sum_en) begin
      blue0_q  <= sat_to_byte(b0);
      green0_q <= sat_to_byte(g0);
      red0_q   <= sat_to_byte(r0);
      blue1_q  <= sat_to_byte(b1);
      green1_q <= sat_to_byte(g1);
      red1_q   <= sat_to_byte(r1);
    end
  end

  assign blue0_o  = blue0_q;
  assign green0_o = green0_q;
  assign red0_o   = red0_q;
  assign blue1_o  = blue1_q;
  assign green1_o = green1_q;
  assign red1_o   = red1_q;

endmodule

FILE: src/nv12_to_bgra_converter_top.sv
// NV12 to BGR pixel-pair converter, limited-range BT.601 integer math.
// Three register stages; throughput one pair per cycle while the output is
// ready, set by the single-port chroma line RAM (one access per pair).
// Each stage holds its item under output backpressure and frees independently.
// Reset clears valids, column counter and sets pairs_per_row to 640; the line
// RAM is not cleared: entries must be written by even rows before odd rows read
// them, which the source must ensure; the block itself does not enforce it.
// Depends on nvb_pkg, nvb_if, nvb_line_buf, nvb_pixel_math.
module nv12_to_bgra_converter_top import nvb_pkg::*; #(
  parameter int MAX_ROW_PAIRS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nvb_cfg_if.sink      cfg,
  nvb_in_if.sink       pix_in,
  nvb_out_if.source    pix_out
);

  localparam int AddrW = (MAX_ROW_PAIRS > 1) ? $clog2(MAX_ROW_PAIRS) : 1;
  localparam int LimW0 = $clog2(MAX_ROW_PAIRS + 1);
  localparam int LimW  = (LimW0 > 11) ? LimW0 : 11;

  logic [10:0]      ppr_q;
  logic [AddrW-1:0] col_q, col_d;
  logic [LimW-1:0]  raw_ext, max_ext, lim, col_ext;
  logic             last;
  logic             accept;
  logic             v1_q, v2_q, v3_q;
  logic             end1_q, end2_q, end3_q;
  logic             fresh1_q;
  logic [7:0]       y0_1_q, y1_1_q;
  logic [15:0]      uv1_q, rd_data, uv_sel;
  stage_en_t        en;
  logic             en1;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q <= 11'd640;
    end else if (cfg.valid) begin
      ppr_q <= cfg.pairs_per_row;
    end
  end

  // Row end: zero width acts as one, widths beyond the RAM depth saturate.
  assign raw_ext = LimW'(ppr_q);
  assign max_ext = LimW'(MAX_ROW_PAIRS);
  assign col_ext = LimW'(col_q);
  always_comb begin
    if (ppr_q == '0) begin
      lim = '0;
    end else if (raw_ext > max_ext) begin
      lim = max_ext - LimW'(1);
    end else begin
      lim = raw_ext - LimW'(1);
    end
  end
  assign last  = (col_ext >= lim);
  assign col_d = last ? '0 : col_q + AddrW'(1);

  assign en.sum_en = !v3_q || pix_out.ready;
  assign en.mul_en = !v2_q || en.sum_en;
  assign en1       = !v1_q || en.mul_en;
  assign pix_in.ready = en1;
  assign accept = pix_in.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
      end
      if (en1) begin
        v1_q <= pix_in.valid;
      end
      if (en.mul_en) begin
        v2_q <= v1_q;
      end
      if (en.sum_en) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      y0_1_q   <= pix_in.payload.luma_first;
      y1_1_q   <= pix_in.payload.luma_second;
      uv1_q    <= {pix_in.payload.chroma_u, pix_in.payload.chroma_v};
      fresh1_q <= pix_in.payload.chroma_fresh;
      end1_q   <= last;
    end
    if (en.mul_en) begin
      end2_q <= end1_q;
    end
    if (en.sum_en) begin
      end3_q <= end2_q;
    end
  end

  // Write and read happen at the same pipeline point, one access per pair,
  // so an odd-row read always sees the earlier even-row write.
  nvb_line_buf #(
    .Depth (MAX_ROW_PAIRS),
    .AddrW (AddrW),
    .DataW (16)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept && pix_in.payload.chroma_fresh),
    .re_i    (accept && !pix_in.payload.chroma_fresh),
    .addr_i  (col_q),
    .wdata_i ({pix_in.payload.chroma_u, pix_in.payload.chroma_v}),
    .rdata_o (rd_data)
  );

  assign uv_sel = fresh1_q ? uv1_q : rd_data;

  nvb_pixel_math u_math (
    .clk_i    (clk_i),
    .en_i     (en),
    .luma0_i  (y0_1_q),
    .luma1_i  (y1_1_q),
    .cb_i     (uv_sel[15:8]),
    .cr_i     (uv_sel[7:0]),
    .blue0_o  (pix_out.payload.blue_first),
    .green0_o (pix_out.payload.green_first),
    .red0_o   (pix_out.payload.red_first),
    .blue1_o  (pix_out.payload.blue_second),
    .green1_o (pix_out.payload.green_second),
    .red1_o   (pix_out.payload.red_second)
  );

  assign pix_out.payload.row_end = end3_q;
  assign pix_out.valid = v3_q;

endmodule

FILE: verif/nv12_to_bgra_converter_top_tb.sv
// Testbench for nv12_to_bgra_converter_top: drives pixel-pair transactions with bursty
// valid and a patterned ready, predicts BGR pairs and row ends in a scoreboard class.
// Depends on nvb_pkg, nvb_if and the converter RTL.
module nv12_to_bgra_converter_top_tb;
  import nvb_pkg::*;

  localparam int ROW_PAIRS_MAX = 1024;
  localparam int LATENCY = 3;
  localparam int RANDOM_PAIRS = 1350;
  localparam int CYCLE_LIMIT = 500000;
  localparam logic [10:0] WIDTH_AT_RESET = 11'd640;

  class bgr_pair_tracker;
    bit [10:0] width_reg = WIDTH_AT_RESET;
    int        col = 0;
    bit        odd_row = 0;
    bit [15:0] line_uv [ROW_PAIRS_MAX];
    bit        stored [ROW_PAIRS_MAX];
    pix_out_t  pending_bgr [$];
    int        bad = 0;

    function int slot();
      return (col >= ROW_PAIRS_MAX) ? ROW_PAIRS_MAX - 1 : col;
    endfunction

    function bit has_chroma();
      return stored[slot()];
    endfunction

    function bit [7:0] clip_sum(int s);
      if (s < 0) begin
        return 8'd0;
      end
      s = s >>> 8;
      if (s > 255) begin
        return 8'd255;
      end
      return s[7:0];
    endfunction

    function void shade(bit [7:0] y, int d, int e,
                        output logic [7:0] b, output logic [7:0] g, output logic [7:0] r);
      int c;
      c = int'(y) - 16;
      if (c < 0) begin
        c = 0;
      end
      b = clip_sum(298 * c + 516 * d + 128);
      g = clip_sum(298 * c - 100 * d - 208 * e + 128);
      r = clip_sum(298 * c + 409 * e + 128);
    endfunction

    function void accept_pair(pix_in_t px);
      int       lim;
      int       s;
      bit [7:0] u;
      bit [7:0] v;
      pix_out_t o;
      lim = int'(width_reg);
      if (lim < 1) begin
        lim = 1;
      end
      if (lim > ROW_PAIRS_MAX) begin
        lim = ROW_PAIRS_MAX;
      end
      s = slot();
      if (px.chroma_fresh) begin
        u = px.chroma_u;
        v = px.chroma_v;
        line_uv[s] = {u, v};
        stored[s] = 1'b1;
      end else begin
        {u, v} = line_uv[s];
      end
      shade(px.luma_first, int'(u) - 128, int'(v) - 128,
            o.blue_first, o.green_first, o.red_first);
      shade(px.luma_second, int'(u) - 128, int'(v) - 128,
            o.blue_second, o.green_second, o.red_second);
      o.row_end = (col >= lim - 1);
      col = o.row_end ? 0 : col + 1;
      if (o.row_end) begin
        odd_row = ~odd_row;
      end
      pending_bgr.push_back(o);
    endfunction

    function void note_field(string field, int want, int got);
      if (want != got) begin
        bad++;
        if (bad <= 10) begin
          $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        end
      end
    endfunction

    function void check_pair(pix_out_t got);
      pix_out_t want;
      if (pending_bgr.size() == 0) begin
        bad++;
        if (bad <= 10) begin
          $display("result with no transaction pending: %p", got);
        end
        return;
      end
      want = pending_bgr.pop_front();
      note_field("blue_first", int'(want.blue_first), int'(got.blue_first));
      note_field("green_first", int'(want.green_first), int'(got.green_first));
      note_field("red_first", int'(want.red_first), int'(got.red_first));
      note_field("blue_second", int'(want.blue_second), int'(got.blue_second));
      note_field("green_second", int'(want.green_second), int'(got.green_second));
      note_field("red_second", int'(want.red_second), int'(got.red_second));
      note_field("row_end", int'(want.row_end), int'(got.row_end));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nvb_cfg_if cfg_bus ();
  nvb_in_if  pix_in_bus ();
  nvb_out_if pix_out_bus ();

  nv12_to_bgra_converter_top #(
    .MAX_ROW_PAIRS(ROW_PAIRS_MAX)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_bus),
    .pix_in (pix_in_bus),
    .pix_out(pix_out_bus)
  );

  bgr_pair_tracker board = new();
  int burst_left = 0;
  bit sending = 0;
  int cycle_cnt = 0;
  int stall_cnt = 0;
  int stall_mode = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver stall pattern, switched at random among four modes
  always @(posedge clk_i) begin
    stall_cnt++;
    if (stall_cnt % 64 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    case (stall_mode)
      0: begin
        pix_out_bus.ready <= 1'b1;
      end
      1: begin
        pix_out_bus.ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        pix_out_bus.ready <= (stall_cnt % 3 == 0);
      end
      default: begin
        pix_out_bus.ready <= (stall_cnt % 16 > 11);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && pix_out_bus.valid && pix_out_bus.ready) begin
      board.check_pair(pix_out_bus.payload);
    end
  end

  task automatic lower_valid();
    if (sending) begin
      pix_in_bus.valid <= 1'b0;
      sending = 0;
    end
  endtask

  task automatic push_pixel(input pix_in_t px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        lower_valid();
        repeat (gap) @(posedge clk_i);
      end
    end
    pix_in_bus.valid <= 1'b1;
    pix_in_bus.payload <= px;
    sending = 1;
    do @(posedge clk_i); while (!pix_in_bus.ready);
    board.accept_pair(px);
    burst_left--;
  endtask

  task automatic settle();
    lower_valid();
    do @(posedge clk_i); while (board.pending_bgr.size() != 0);
  endtask

  task automatic write_pairs_per_row(input logic [10:0] w);
    cfg_bus.valid <= 1'b1;
    cfg_bus.pairs_per_row <= w;
    do @(posedge clk_i); while (!cfg_bus.ready);
    board.width_reg = w;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic send_pair(input logic [7:0] y1, input logic [7:0] y2,
                           input logic [7:0] u, input logic [7:0] v, input logic fresh);
    pix_in_t px;
    px.luma_first = y1;
    px.luma_second = y2;
    px.chroma_u = u;
    px.chroma_v = v;
    px.chroma_fresh = fresh;
    push_pixel(px);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner_vals [10] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17,
                                     8'd127, 8'd128, 8'd235, 8'd254, 8'd255};
    if ($urandom_range(0, 7) == 0) begin
      return corner_vals[$urandom_range(0, 9)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly well-formed rows: even rows bring chroma, odd rows reuse it
  function automatic pix_in_t random_pair();
    pix_in_t px;
    bit      want_fresh;
    px.luma_first = pick_byte();
    px.luma_second = pick_byte();
    px.chroma_u = pick_byte();
    px.chroma_v = pick_byte();
    want_fresh = !board.odd_row;
    if ($urandom_range(0, 9) == 0) begin
      want_fresh = !want_fresh;
    end
    if (!board.has_chroma()) begin
      want_fresh = 1'b1;
    end
    px.chroma_fresh = want_fresh;
    return px;
  endfunction

  function automatic logic [10:0] pick_width();
    case ($urandom_range(0, 15))
      0: return 11'd0;
      1: return 11'd2047;
      2: return 11'd1024;
      3: return 11'd1;
      4: return 11'd1025;
      5: return 11'($urandom_range(17, 300));
      default: return 11'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin
    int n;
    int random_sent;
    int phase;
    rst_ni <= 1'b0;
    pix_in_bus.valid <= 1'b0;
    pix_in_bus.payload <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.pairs_per_row <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset width, then shrink mid-row so the next pair must end the row
    send_pair(8'd0, 8'd255, 8'd128, 8'd128, 1'b1);
    send_pair(8'd16, 8'd235, 8'd0, 8'd255, 1'b1);
    settle();
    write_pairs_per_row(11'd2);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pair(8'd17, 8'd15, 8'd255, 8'd0, 1'b1);
    send_pair(8'd128, 8'd64, 8'd0, 8'd0, 1'b1);
    send_pair(8'd255, 8'd0, 8'd255, 8'd255, 1'b0);
    send_pair(8'd0, 8'd255, 8'd0, 8'd255, 1'b0);
    send_pair(8'd240, 8'd16, 8'd255, 8'd255, 1'b1);
    send_pair(8'd255, 8'd255, 8'd0, 8'd255, 1'b1);
    send_pair(8'd100, 8'd200, 8'd170, 8'd85, 1'b0);
    send_pair(8'd255, 8'd16, 8'd85, 8'd170, 1'b0);
    settle();
    // zero width acts as one pair per row
    write_pairs_per_row(11'd0);
    send_pair(8'd255, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pair(8'd200, 8'd50, 8'd255, 8'd255, 1'b0);
    settle();
    // oversized width saturates at the line buffer depth
    write_pairs_per_row(11'd2047);
    send_pair(8'd90, 8'd180, 8'd1, 8'd1, 1'b0);
    send_pair(8'd235, 8'd16, 8'd90, 8'd240, 1'b1);
    send_pair(8'd128, 8'd128, 8'd240, 8'd90, 1'b1);
    settle();
    write_pairs_per_row(11'd1);
    send_pair(8'd1, 8'd254, 8'd1, 8'd254, 1'b1);

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_PAIRS) begin
      settle();
      write_pairs_per_row(pick_width());
      n = $urandom_range(20, 120);
      for (int k = 0; k < n && random_sent < RANDOM_PAIRS; k++) begin
        if (k == n / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) begin
          settle();
        end
        push_pixel(random_pair());
        random_sent++;
      end
      phase++;
    end

    settle();
    repeat (LATENCY * 4) @(posedge clk_i);
    if (board.bad == 0 && board.pending_bgr.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
